[sv/psg_pkg.sv]
package psg_pkg;

    // Width of the period and count registers, which count samples in 11.16.
    localparam int PER_W = 27;
    // Width of the modular sum that forms one high time.
    localparam int HI_W = 28;
    localparam int GAIN_W = 14;
    localparam int STEP_W = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] REG_NOISE = 3'd6;
    localparam logic [1:0] NOISE_MODE_TONE2 = 2'd3;

    localparam logic [16:0] NOISE_WHITE    = 17'h14002;
    localparam logic [16:0] NOISE_PERIODIC = 17'h08000;
    localparam logic [16:0] NOISE_PRESET   = 17'h00f35;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd15052;

    typedef struct packed {
        logic       wr;
        logic       t_load;
        logic       div_step;
        logic       t_fin;
        logic       t_mac;
        logic       n_init;
        logic       n_step;
        logic       n_mac;
        logic       dc_mul;
        logic       dc_fin;
        logic       out_load;
        logic [1:0] ch;
    } psg_cmd_t;

    typedef struct packed {
        logic noise_done;
    } psg_stat_t;

    // Attenuation in 2 dB steps; the last code mutes the channel.
    function automatic logic [GAIN_W-1:0] gain_lut(input logic [3:0] code);
        logic [GAIN_W-1:0] g;
        unique case (code)
            4'd0:  g = 14'd10922;
            4'd1:  g = 14'd8675;
            4'd2:  g = 14'd6891;
            4'd3:  g = 14'd5473;
            4'd4:  g = 14'd4348;
            4'd5:  g = 14'd3453;
            4'd6:  g = 14'd2743;
            4'd7:  g = 14'd2179;
            4'd8:  g = 14'd1731;
            4'd9:  g = 14'd1374;
            4'd10: g = 14'd1092;
            4'd11: g = 14'd867;
            4'd12: g = 14'd689;
            4'd13: g = 14'd547;
            4'd14: g = 14'd434;
            default: g = 14'd0;
        endcase
        return g;
    endfunction

endpackage

[sv/psg_if.sv]
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic       chip_select;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output chip_select, output data_byte,
                    input ready);
    modport sink (input valid, input opcode, input chip_select, input data_byte,
                  output ready);
endinterface

interface psg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

[sv/psg_ctrl.sv]
module psg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    input  logic                out_ready,
    input  psg_pkg::psg_stat_t  stat,
    output psg_pkg::psg_cmd_t   cmd,
    output logic                in_ready,
    output logic                out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_LOAD,
        ST_T_DIV,
        ST_T_FIN,
        ST_T_MAC,
        ST_N_INIT,
        ST_N_STEP,
        ST_N_MAC,
        ST_D_MUL,
        ST_D_FIN,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic [3:0] div_cnt_reg, div_cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        div_cnt_next   = div_cnt_reg;
        cmd            = '0;
        cmd.ch         = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_opcode == psg_pkg::OP_WRITE)
                begin
                    cmd.wr = 1'b1;
                end
                else if (in_valid)
                begin
                    ch_next    = 2'd0;
                    state_next = ST_T_LOAD;
                end
            end
            ST_T_LOAD:
            begin
                cmd.t_load   = 1'b1;
                div_cnt_next = 4'd0;
                state_next   = ST_T_DIV;
            end
            ST_T_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = ST_T_FIN;
                end
            end
            ST_T_FIN:
            begin
                cmd.t_fin  = 1'b1;
                state_next = ST_T_MAC;
            end
            ST_T_MAC:
            begin
                cmd.t_mac = 1'b1;
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_N_INIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_T_LOAD;
                end
            end
            ST_N_INIT:
            begin
                cmd.n_init = 1'b1;
                state_next = ST_N_STEP;
            end
            ST_N_STEP:
            begin
                if (stat.noise_done)
                begin
                    state_next = ST_N_MAC;
                end
                else
                begin
                    cmd.n_step = 1'b1;
                end
            end
            ST_N_MAC:
            begin
                cmd.n_mac  = 1'b1;
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.dc_mul = 1'b1;
                state_next = ST_D_FIN;
            end
            ST_D_FIN:
            begin
                cmd.dc_fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 2'd0;
            div_cnt_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[sv/psg_datapath.sv]
module psg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                chip_select,
    input  logic [7:0]          data_byte,
    input  psg_pkg::psg_cmd_t   cmd,
    output psg_pkg::psg_stat_t  stat,
    output logic signed [15:0]  sample_out
);

    localparam int PW = psg_pkg::PER_W;
    localparam int HW = psg_pkg::HI_W;
    localparam int GW = psg_pkg::GAIN_W;

    // Architectural state.
    logic [15:0]    step_reg;
    logic [2:0]     lat_reg [2];
    logic [9:0]     tf_reg [3];
    logic [9:0]     nf2_reg;
    logic [3:0]     nctl_reg;
    logic [GW-1:0]  gain_reg [3];
    logic [GW-1:0]  ngain_reg;
    logic [PW-1:0]  tp_reg [3];
    logic [PW-1:0]  np2_reg;
    logic [PW-1:0]  nper_reg;
    logic [PW-1:0]  cnt_reg [3];
    logic [PW-1:0]  ncnt_reg;
    logic           lvl_reg [3];
    logic           nlvl_reg;
    logic [16:0]    shf_reg;
    logic [16:0]    fb_reg;
    logic [14:0]    xprev_reg;
    logic signed [39:0] yprev_reg;

    // Working registers.
    logic [PW-1:0]  w_c_reg;
    logic [PW-1:0]  w_p_reg;
    logic           w_l_reg;
    logic [15:0]    w_d_reg;
    logic [15:0]    dq_reg;
    logic [15:0]    rem_reg;
    logic [17:0]    hi_reg;
    logic [33:0]    acc_reg;
    logic [14:0]    tone_reg;
    logic [16:0]    left_reg;
    logic [16:0]    nhi_reg;
    logic [14:0]    noise_reg;
    logic [14:0]    x_reg;
    logic signed [50:0] dct_reg;
    logic signed [15:0] s_hold_reg;
    logic signed [15:0] out_reg;

    function automatic logic [14:0] clamp_mix(input logic [33:0] v);
        if (v > 34'h07fff0000)
        begin
            return 15'h7fff;
        end
        return v[30:16];
    endfunction

    // ---------------- register write ----------------
    logic [15:0]   eff;
    logic [2:0]    wsel;
    logic [1:0]    wch;
    logic          is_latch, is_tone;
    logic [9:0]    f_old, f_new;
    logic [25:0]   f_prod;
    logic [PW-1:0] p_new, np_new;

    always_comb
    begin
        eff      = (step_reg == 16'd0) ? 16'd1 : step_reg;
        is_latch = data_byte[7];
        wsel     = is_latch ? data_byte[6:4] : lat_reg[chip_select];
        wch      = wsel[2:1];
        is_tone  = (wsel == 3'd0) || (wsel == 3'd2) || (wsel == 3'd4);
        case (wch)
            2'd0:    f_old = chip_select ? 10'd0 : tf_reg[0];
            2'd1:    f_old = chip_select ? 10'd0 : tf_reg[1];
            default: f_old = chip_select ? nf2_reg : tf_reg[2];
        endcase
        f_new  = is_latch ? {f_old[9:4], data_byte[3:0]} : {data_byte[5:0], f_old[3:0]};
        f_prod = eff * f_new;
        p_new  = (f_prod == 26'd0) ? PW'(eff) : PW'(f_prod);
        case (data_byte[1:0])
            2'd0:    np_new = PW'(eff) << 5;
            2'd1:    np_new = PW'(eff) << 6;
            2'd2:    np_new = PW'(eff) << 7;
            default: np_new = np2_reg << 1;
        endcase
    end

    // ---------------- tone divider and finish ----------------
    logic [PW-1:0] c_sel, p_sel;
    logic          l_sel;
    logic [GW-1:0] g_sel;
    logic [16:0]   rem_sh;
    logic          div_ge;
    logic          nowrap, tog, l_new;
    logic [15:0]   qp;
    logic [HW-1:0] half, hi_sum;
    logic [PW-1:0] c_new;

    always_comb
    begin
        case (cmd.ch)
            2'd0:
            begin
                c_sel = cnt_reg[0]; p_sel = tp_reg[0]; l_sel = lvl_reg[0]; g_sel = gain_reg[0];
            end
            2'd1:
            begin
                c_sel = cnt_reg[1]; p_sel = tp_reg[1]; l_sel = lvl_reg[1]; g_sel = gain_reg[1];
            end
            default:
            begin
                c_sel = cnt_reg[2]; p_sel = tp_reg[2]; l_sel = lvl_reg[2]; g_sel = gain_reg[2];
            end
        endcase

        rem_sh = {rem_reg, dq_reg[15]};
        div_ge = {{(PW-17){1'b0}}, rem_sh} >= w_p_reg;

        nowrap = w_c_reg > PW'(65536);
        qp     = w_d_reg - rem_reg;
        // q*p is d-r, so the whole periods before the last edge need no multiply.
        if (dq_reg[0])
        begin
            half = (HW'(qp) + HW'(w_p_reg)) >> 1;
        end
        else
        begin
            half = HW'(qp >> 1);
        end
        tog = ~dq_reg[0];
        if (nowrap)
        begin
            l_new  = w_l_reg;
            c_new  = w_c_reg - PW'(65536);
            hi_sum = w_l_reg ? HW'(65536) : HW'(0);
        end
        else
        begin
            l_new  = w_l_reg ^ tog;
            c_new  = w_p_reg - PW'(rem_reg);
            hi_sum = (w_l_reg ? HW'(w_c_reg) : HW'(0)) + half
                   + ((tog && l_new) ? HW'(w_p_reg) : HW'(0))
                   - (l_new ? HW'(c_new) : HW'(0));
        end
    end

    // ---------------- noise step ----------------
    logic [16:0] lfsr_next;
    logic        n_noevent;

    always_comb
    begin
        lfsr_next = shf_reg[0] ? (shf_reg ^ fb_reg) : shf_reg;
        lfsr_next = lfsr_next >> 1;
        n_noevent = ncnt_reg > PW'(left_reg);
    end

    // ---------------- DC blocker ----------------
    logic signed [16:0] dx;
    logic signed [41:0] y_full;
    logic signed [39:0] y_sat;
    logic [40:0]        y_mag;
    logic [24:0]        y_rnd;
    logic signed [15:0] s_val;

    always_comb
    begin
        dx     = $signed({2'b00, x_reg}) - $signed({2'b00, xprev_reg});
        y_full = ($signed(42'(dx)) <<< 16) + 42'(yprev_reg) + 42'(dct_reg >>> 18);
        if (y_full > 42'sd549755813887)
        begin
            y_sat = 40'sh7fffffffff;
        end
        else if (y_full < -42'sd549755813888)
        begin
            y_sat = -40'sh8000000000;
        end
        else
        begin
            y_sat = 40'(y_full);
        end
        y_mag = y_sat[39] ? 41'(-42'(y_sat)) : 41'(y_sat);
        y_rnd = 25'((y_mag + 41'd32768) >> 16);
        if (!y_sat[39])
        begin
            s_val = (y_rnd > 25'd32767) ? 16'sd32767 : $signed(16'(y_rnd));
        end
        else
        begin
            s_val = (y_rnd > 25'd32768) ? -16'sd32768 : $signed(16'(-y_rnd));
        end
    end

    // ---------------- architectural state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= psg_pkg::STEP_RESET;
            lat_reg   <= '{default: 3'd0};
            tf_reg    <= '{default: 10'd0};
            nf2_reg   <= 10'd0;
            nctl_reg  <= 4'd0;
            gain_reg  <= '{default: '0};
            ngain_reg <= '0;
            tp_reg    <= '{default: PW'(psg_pkg::STEP_RESET)};
            np2_reg   <= PW'(psg_pkg::STEP_RESET);
            nper_reg  <= PW'(psg_pkg::STEP_RESET);
            cnt_reg   <= '{default: PW'(psg_pkg::STEP_RESET)};
            ncnt_reg  <= PW'(psg_pkg::STEP_RESET);
            lvl_reg   <= '{default: 1'b0};
            nlvl_reg  <= 1'b0;
            shf_reg   <= 17'd0;
            fb_reg    <= 17'd0;
            xprev_reg <= 15'd0;
            yprev_reg <= 40'sd0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (cmd.wr)
            begin
                if (is_latch)
                begin
                    lat_reg[chip_select] <= data_byte[6:4];
                end
                if (is_tone)
                begin
                    if (!chip_select)
                    begin
                        tf_reg[wch] <= f_new;
                        tp_reg[wch] <= p_new;
                    end
                    else if (wch == 2'd2)
                    begin
                        nf2_reg <= f_new;
                        np2_reg <= p_new;
                        if (nctl_reg[1:0] == psg_pkg::NOISE_MODE_TONE2)
                        begin
                            nper_reg <= p_new << 1;
                        end
                    end
                end
                if (is_latch && data_byte[4])
                begin
                    if (!chip_select && wch != 2'd3)
                    begin
                        gain_reg[wch] <= psg_pkg::gain_lut(data_byte[3:0]);
                    end
                    else if (chip_select && wch == 2'd3)
                    begin
                        ngain_reg <= psg_pkg::gain_lut(data_byte[3:0]);
                    end
                end
                if (is_latch && chip_select && data_byte[6:4] == psg_pkg::REG_NOISE)
                begin
                    nctl_reg <= data_byte[3:0];
                    fb_reg   <= data_byte[2] ? psg_pkg::NOISE_WHITE : psg_pkg::NOISE_PERIODIC;
                    nper_reg <= np_new;
                    shf_reg  <= psg_pkg::NOISE_PRESET;
                    nlvl_reg <= psg_pkg::NOISE_PRESET[0];
                end
            end
            if (cmd.t_fin && cmd.ch != 2'd3)
            begin
                cnt_reg[cmd.ch] <= c_new;
                lvl_reg[cmd.ch] <= l_new;
            end
            if (cmd.n_step)
            begin
                if (n_noevent)
                begin
                    ncnt_reg <= ncnt_reg - PW'(left_reg);
                end
                else
                begin
                    shf_reg  <= lfsr_next;
                    nlvl_reg <= lfsr_next[0];
                    ncnt_reg <= nper_reg;
                end
            end
            if (cmd.dc_fin)
            begin
                xprev_reg <= x_reg;
                yprev_reg <= y_sat;
            end
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.t_load)
        begin
            w_c_reg <= c_sel;
            w_p_reg <= p_sel;
            w_l_reg <= l_sel;
            w_d_reg <= 16'(17'd65536 - c_sel[16:0]);
            dq_reg  <= 16'(17'd65536 - c_sel[16:0]);
            rem_reg <= 16'd0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? 16'(rem_sh - w_p_reg[16:0]) : rem_sh[15:0];
            dq_reg  <= {dq_reg[14:0], div_ge};
        end
        if (cmd.t_fin)
        begin
            hi_reg <= hi_sum[17:0];
        end
        if (cmd.t_mac)
        begin
            acc_reg <= ((cmd.ch == 2'd0) ? 34'd0 : acc_reg) + 34'(hi_reg) * 34'(g_sel);
        end
        if (cmd.n_init)
        begin
            tone_reg <= clamp_mix(acc_reg);
            left_reg <= (ngain_reg == '0) ? 17'd0 : 17'd65536;
            nhi_reg  <= 17'd0;
        end
        if (cmd.n_step)
        begin
            if (n_noevent)
            begin
                nhi_reg  <= nhi_reg + (nlvl_reg ? left_reg : 17'd0);
                left_reg <= 17'd0;
            end
            else
            begin
                nhi_reg  <= nhi_reg + (nlvl_reg ? ncnt_reg[16:0] : 17'd0);
                left_reg <= left_reg - ncnt_reg[16:0];
            end
        end
        if (cmd.n_mac)
        begin
            noise_reg <= clamp_mix(34'(nhi_reg) * 34'(ngain_reg));
        end
        if (cmd.dc_mul)
        begin
            x_reg   <= 15'(({1'b0, tone_reg} + {1'b0, noise_reg}) >> 1);
            dct_reg <= 51'sd131072 - 51'(yprev_reg) * 51'sd372;
        end
        if (cmd.dc_fin)
        begin
            s_hold_reg <= s_val;
        end
        if (cmd.out_load)
        begin
            out_reg <= s_hold_reg;
        end
    end

    assign stat.noise_done = (left_reg == 17'd0);
    assign sample_out      = out_reg;

endmodule

[sv/psg_tone_noise_sample_generator.sv]
// Two register-compatible PSG instances behind one byte port: words with
// chip_select clear go to the tone instance, whose three square-wave channels
// are heard, and words with chip_select set go to the noise instance, of
// which only the noise channel is heard. A write word is taken at once and
// the block is ready again straight after. A sample word walks the channels
// one at a time: each tone channel is loaded, run through the shared
// bit-serial divider that finds how many half-periods fit in the step,
// finished and added to the mix. The noise channel is then set up and
// advances once per cycle, one advance for each noise edge inside the step
// and one more for the stretch after the last edge unless that edge ends the
// step exactly, and then sees that the step is used up; a muted noise channel
// makes no advance. The sample then passes the noise mix and the DC blocker
// on its way to the output register, where it waits for the sink. The
// update_step register sets the step in samples per chip step as unsigned
// 0.16; the user must write it through cfg_we and cfg_wdata only while the
// block is idle, and the block itself does not enforce this.
module psg_tone_noise_sample_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    psg_in_if.sink      in_ch,
    psg_out_if.source   out_ch
);

    psg_pkg::psg_cmd_t  cmd;
    psg_pkg::psg_stat_t stat;

    // The controller sequences one sample word through the channel engine.
    psg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    // The datapath holds the register file, channel state and the mixer.
    psg_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .chip_select (in_ch.chip_select),
        .data_byte   (in_ch.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .sample_out  (out_ch.sample_out)
    );

endmodule

[sv/psg_checker.sv]
module psg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample_out
);

    // A waiting sample holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("output word changed while stalled");

    // A sample word occupies the engine for at least the next cycle.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_opcode |=> !in_ready)
        else $error("ready after accepting a sample word");

    // A write word completes in the cycle it is taken.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_opcode |=> in_ready)
        else $error("write word stalled the input");

    // A new result only appears at the end of a busy stretch.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a sample in progress");

endmodule

bind psg_tone_noise_sample_generator psg_checker u_psg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out)
);
